>>> rtl/lruttl_pkg.sv
// Shared codes, command and status types for the LRU cache with time-to-live.
package lruttl_pkg;

   localparam logic [1:0] MODE_GET   = 2'd0;
   localparam logic [1:0] MODE_PUT   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_MISS     = 3'd1;
   localparam logic [2:0] ST_EXPIRED  = 3'd2;
   localparam logic [2:0] ST_UPDATED  = 3'd3;
   localparam logic [2:0] ST_INSERTED = 3'd4;
   localparam logic [2:0] ST_CLEARED  = 3'd5;

   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_TTL      = 1'b1;

   typedef enum logic [1:0] {
      SW_MRU,
      SW_DROP,
      SW_INS
   } sweep_kind_type;

   typedef struct packed {
      logic           load;
      logic           start_look;
      logic           start_sweep;
      sweep_kind_type kind;
      logic           finish;
   } dp_cmd_type;

   typedef struct packed {
      logic       busy;
      logic       hit;
      logic       expired;
      logic       rsp_free;
      logic [1:0] mode;
   } dp_stat_type;

endpackage

>>> rtl/lru_cache_with_ttl.sv
// Top level: fully associative LRU key/value cache with optional time-to-live.
// Sequence: a get hit, an expired get or any put makes one scan of the entry memories
//   to find the key and one sweep to fix the ranks before its result beat; a get miss
//   skips the sweep, and clear and unused modes skip both.
// Throughput: one beat is in work at a time; the next request is taken once the controller is
//   back in idle, and a finished result beat waits in the output register meanwhile.
// Reset (synchronous, active high) empties the cache, zeroes both counters and
//   restores capacity 64 and ttl 0; no clearing pass is needed.
module lru_cache_with_ttl import lruttl_pkg::*; #(
   parameter int ENTRIES  = 64,
   parameter int KEY_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [63:0]        req_lookup_key,
   input  logic signed [31:0] req_put_value,
   input  logic [63:0]        req_now_ms,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_evicted,
   output logic [63:0]        rsp_hits_total,
   output logic [63:0]        rsp_misses_total
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // the user must write configuration only while idle (the block does not enforce it), so take every beat at once
   assign csr_ready = 1'b1;

   // sequence: accept, scan for the key, decide, sweep the ranks, hand over
   lruttl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold entries, ranks, counters and the result register
   lruttl_dp #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_lookup_key   (req_lookup_key),
      .req_put_value    (req_put_value),
      .req_now_ms       (req_now_ms),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .rsp_hits_total   (rsp_hits_total),
      .rsp_misses_total (rsp_misses_total)
   );

endmodule

>>> rtl/lruttl_ctrl.sv
// Controller state machine sequencing lookup and update sweeps.
module lruttl_ctrl import lruttl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_mode,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOOK   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_SWEEP  = 5'b01000,
      S_FIN    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_mode == MODE_GET || req_mode == MODE_PUT) begin
                  cmd.start_look = 1'b1;
                  state_in       = S_LOOK;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_LOOK: begin
            if (!stat.busy) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in        = S_SWEEP;
            cmd.start_sweep = 1'b1;
            priority if (stat.mode == MODE_GET && !stat.hit) begin
               cmd.start_sweep = 1'b0;
               state_in        = S_FIN;
            end else if (stat.mode == MODE_GET && stat.expired) begin
               cmd.kind = SW_DROP;
            end else if (stat.hit) begin
               cmd.kind = SW_MRU;
            end else begin
               cmd.kind = SW_INS;
            end
         end
         S_SWEEP: begin
            if (!stat.busy) state_in = S_FIN;
         end
         S_FIN: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/lruttl_dp.sv
// Datapath: entry memories, scan pipeline, recency ranks, counters and result register.
module lruttl_dp import lruttl_pkg::*; #(
   parameter int ENTRIES  = 64,
   parameter int KEY_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic [1:0]         req_mode,
   input  logic [63:0]        req_lookup_key,
   input  logic signed [31:0] req_put_value,
   input  logic [63:0]        req_now_ms,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_evicted,
   output logic [63:0]        rsp_hits_total,
   output logic [63:0]        rsp_misses_total
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int WW = (CW > 7) ? CW : 7;

   logic [6:0]          cap_ff;
   logic [31:0]         ttl_ff;
   logic [1:0]          mode_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [31:0]         val_ff;
   logic [63:0]         now_ff;

   logic [KEY_BITS-1:0] key_mem   [ENTRIES];
   logic [31:0]         val_mem   [ENTRIES];
   logic [63:0]         stamp_mem [ENTRIES];
   logic [AW-1:0]       rank_mem  [ENTRIES];

   logic [ENTRIES-1:0]  valid_ff;
   logic [CW-1:0]       count_ff;
   logic [63:0]         hits_ff, miss_ff;

   logic [AW:0]         cnt_ff;
   logic                p_vld_ff;
   logic [AW-1:0]       p_idx_ff;
   logic                looking_ff;
   sweep_kind_type      kind_ff;

   logic [KEY_BITS-1:0] key_rd_ff;
   logic [31:0]         val_rd_ff;
   logic [63:0]         stamp_rd_ff;
   logic [AW-1:0]       rank_rd_ff;

   logic                hit_ff, expired_ff, evict_ff, free_found_ff;
   logic [AW-1:0]       slot_ff, hrank_ff, free_ff;
   logic [31:0]         hval_ff;
   logic [63:0]         hstamp_ff;

   logic                rsp_valid_ff, rsp_evicted_ff;
   logic [2:0]          rsp_status_ff;
   logic [31:0]         rsp_value_ff;

   // effective capacity, clamped to 1..ENTRIES
   logic [WW-1:0] cap_w;
   logic [CW-1:0] cap_eff;
   logic          evict_en;
   logic [AW-1:0] thr;

   always_comb begin
      cap_w = WW'(cap_ff);
      priority if (cap_w == '0)                cap_eff = CW'(1);
      else if (cap_w > WW'(ENTRIES))           cap_eff = CW'(ENTRIES);
      else                                     cap_eff = CW'(cap_w);
      evict_en = (count_ff >= cap_eff);
      thr      = AW'(cap_eff - CW'(1));
   end

   logic          issuing;
   logic [AW-1:0] rd_addr;
   assign issuing = (cnt_ff < (AW+1)'(ENTRIES));
   assign rd_addr = issuing ? cnt_ff[AW-1:0] : '0;

   // per-entry processing of the beat leaving the read stage
   logic          cur_v, proc_look, proc_sweep, ins_evict;
   logic [AW-1:0] cur_r;
   logic          rank_we;
   logic [AW-1:0] rank_wa, rank_wd;

   logic fin, fin_drop, fin_upd, fin_ins;

   always_comb begin
      cur_v      = valid_ff[p_idx_ff];
      cur_r      = rank_rd_ff;
      proc_look  = p_vld_ff && looking_ff;
      proc_sweep = p_vld_ff && !looking_ff;
      ins_evict  = proc_sweep && kind_ff == SW_INS && cur_v && evict_en && cur_r >= thr;
      rank_we    = 1'b0;
      rank_wa    = p_idx_ff;
      rank_wd    = '0;
      if (proc_sweep) begin
         unique case (kind_ff)
            SW_MRU: begin
               if (cur_v && cur_r < hrank_ff) begin
                  rank_we = 1'b1;
                  rank_wd = cur_r + AW'(1);
               end else if (p_idx_ff == slot_ff) begin
                  rank_we = 1'b1;
               end
            end
            SW_DROP: begin
               if (cur_v && cur_r > hrank_ff) begin
                  rank_we = 1'b1;
                  rank_wd = cur_r - AW'(1);
               end
            end
            SW_INS: begin
               if (cur_v && !ins_evict) begin
                  rank_we = 1'b1;
                  rank_wd = cur_r + AW'(1);
               end
            end
            default: rank_we = 1'b0;
         endcase
      end
      fin      = cmd.finish;
      fin_drop = fin && mode_ff == MODE_GET && hit_ff && expired_ff;
      fin_upd  = fin && mode_ff == MODE_PUT && hit_ff;
      fin_ins  = fin && mode_ff == MODE_PUT && !hit_ff;
      if (fin_ins) begin
         rank_we = 1'b1;
         rank_wa = free_ff;
         rank_wd = '0;
      end
   end

   // configuration and request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 7'd64;
         ttl_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAPACITY: cap_ff <= csr_wdata[6:0];
            CSR_TTL:      ttl_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         key_ff  <= req_lookup_key[KEY_BITS-1:0];
         val_ff  <= req_put_value;
         now_ff  <= req_now_ms;
      end
   end

   // scan pipeline: issue address, then process registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= (AW+1)'(ENTRIES);
         p_vld_ff <= 1'b0;
      end else begin
         if (cmd.start_look || cmd.start_sweep) cnt_ff <= '0;
         else if (issuing)                      cnt_ff <= cnt_ff + (AW+1)'(1);
         p_vld_ff <= issuing;
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff <= rd_addr;
      if (cmd.start_look)  looking_ff <= 1'b1;
      if (cmd.start_sweep) begin
         looking_ff <= 1'b0;
         kind_ff    <= cmd.kind;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      key_rd_ff   <= key_mem[rd_addr];
      val_rd_ff   <= val_mem[rd_addr];
      stamp_rd_ff <= stamp_mem[rd_addr];
      rank_rd_ff  <= rank_mem[rd_addr];
      if (fin_ins) key_mem[free_ff] <= key_ff;
      if (fin_ins || fin_upd) begin
         val_mem[fin_ins ? free_ff : slot_ff]   <= val_ff;
         stamp_mem[fin_ins ? free_ff : slot_ff] <= now_ff;
      end
      if (rank_we) rank_mem[rank_wa] <= rank_wd;
   end

   // lookup capture, expiry test, insert bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.start_look) hit_ff <= 1'b0;
      else if (proc_look && cur_v && key_rd_ff == key_ff && !hit_ff) begin
         hit_ff    <= 1'b1;
         slot_ff   <= p_idx_ff;
         hval_ff   <= val_rd_ff;
         hstamp_ff <= stamp_rd_ff;
         hrank_ff  <= cur_r;
      end
      expired_ff <= (ttl_ff != '0) && ((now_ff - hstamp_ff) > {32'd0, ttl_ff});
      if (cmd.start_sweep) begin
         evict_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (proc_sweep && kind_ff == SW_INS) begin
         if (ins_evict) evict_ff <= 1'b1;
         if (!free_found_ff && (!cur_v || ins_evict)) begin
            free_found_ff <= 1'b1;
            free_ff       <= p_idx_ff;
         end
      end
   end

   // valid bits, fill count, counters
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         hits_ff  <= '0;
         miss_ff  <= '0;
      end else begin
         if (ins_evict) valid_ff[p_idx_ff] <= 1'b0;
         if (fin && mode_ff == MODE_CLEAR) begin
            valid_ff <= '0;
            count_ff <= '0;
         end
         if (fin_drop) begin
            valid_ff[slot_ff] <= 1'b0;
            count_ff          <= count_ff - CW'(1);
         end
         if (fin_ins) begin
            valid_ff[free_ff] <= 1'b1;
            count_ff          <= evict_en ? cap_eff : count_ff + CW'(1);
         end
         if (fin && mode_ff == MODE_GET) begin
            if (hit_ff && !expired_ff) hits_ff <= hits_ff + 64'd1;
            else                       miss_ff <= miss_ff + 64'd1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (fin)       rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_value_ff   <= '0;
         rsp_evicted_ff <= 1'b0;
         unique case (mode_ff)
            MODE_GET: begin
               priority if (!hit_ff)  rsp_status_ff <= ST_MISS;
               else if (expired_ff)   rsp_status_ff <= ST_EXPIRED;
               else begin
                  rsp_status_ff <= ST_HIT;
                  rsp_value_ff  <= hval_ff;
               end
            end
            MODE_PUT: begin
               if (hit_ff) rsp_status_ff <= ST_UPDATED;
               else begin
                  rsp_status_ff  <= ST_INSERTED;
                  rsp_evicted_ff <= evict_ff;
               end
            end
            MODE_CLEAR: rsp_status_ff <= ST_CLEARED;
            default:    rsp_status_ff <= ST_MISS;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_value   = $signed(rsp_value_ff);
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_hits_total   = hits_ff;
   assign rsp_misses_total = miss_ff;

   always_comb begin
      stat.busy     = issuing || p_vld_ff;
      stat.hit      = hit_ff;
      stat.expired  = expired_ff;
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
      stat.mode     = mode_ff;
   end

endmodule

>>> rtl/lruttl_chk.sv
// Port-level checker for the LRU cache, bound to the top level.
module lruttl_chk import lruttl_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_mode,
   input logic [63:0]        req_lookup_key,
   input logic signed [31:0] req_put_value,
   input logic [63:0]        req_now_ms,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic               csr_index,
   input logic [31:0]        csr_wdata,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_status,
   input logic signed [31:0] rsp_read_value,
   input logic               rsp_evicted,
   input logic [63:0]        rsp_hits_total,
   input logic [63:0]        rsp_misses_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result beat dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_evict_on_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_status == ST_INSERTED)
      else $error("eviction flagged on a non-insert result");

   a_value_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_HIT |-> rsp_read_value == 0)
      else $error("nonzero read value on a non-hit result");

   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) && !rsp_valid ##1 !rsp_valid |->
      $stable(rsp_hits_total) && $stable(rsp_misses_total))
      else $error("counters moved without a result");

endmodule

bind lru_cache_with_ttl lruttl_chk u_chk (.*);

>>> tb/lru_cache_with_ttl_tb.sv
// Self-checking testbench for the LRU cache with time-to-live: table, random traffic, predictor.
module lru_cache_with_ttl_tb;
   import lruttl_pkg::*;

   localparam int ENTRIES    = 64;
   localparam int STALL_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_GET;
   logic [63:0]        req_lookup_key = '0;
   logic signed [31:0] req_put_value = '0;
   logic [63:0]        req_now_ms = '0;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = CSR_CAPACITY;
   logic [31:0]        csr_wdata = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_read_value;
   logic               rsp_evicted;
   logic [63:0]        rsp_hits_total;
   logic [63:0]        rsp_misses_total;

   lru_cache_with_ttl u_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_lookup_key, .req_put_value, .req_now_ms,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_read_value, .rsp_evicted,
      .rsp_hits_total, .rsp_misses_total
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      logic [2:0]  status;
      logic [31:0] value;
      logic        evicted;
      logic [63:0] hits;
      logic [63:0] misses;
   } cache_result_type;

   typedef struct {
      logic [1:0]  mode;
      logic [63:0] key;
      logic [31:0] value;
      logic [63:0] now;
      logic        known;   // a typed-in result follows
      logic [2:0]  status;
      logic [31:0] rd;
   } table_row_type;

   // shadow copy of the cache
   logic [63:0] shadow_key   [ENTRIES];
   logic [31:0] shadow_value [ENTRIES];
   logic [63:0] shadow_stamp [ENTRIES];
   logic        shadow_live  [ENTRIES];
   int unsigned shadow_rank  [ENTRIES];
   int unsigned shadow_count;
   logic [63:0] shadow_hits, shadow_misses;
   logic [6:0]  shadow_capacity;
   logic [31:0] shadow_ttl;

   cache_result_type pending_results[$];
   table_row_type    directed[$];
   int            error_count = 0;
   int            idle_cycles = 0;
   bit            timed_out = 0;
   bit            quiet_mode = 0;   // no idling on either side
   bit            hold_off = 0;     // receiver holds off on request
   logic [63:0]   clock_ms = 64'd1000;
   logic [63:0]   key_pool[8];

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic shadow_drop(input int slot);
      int unsigned r;
      r = shadow_rank[slot];
      shadow_live[slot] = 1'b0;
      for (int i = 0; i < ENTRIES; i++)
         if (shadow_live[i] && shadow_rank[i] > r) shadow_rank[i]--;
      if (shadow_count > 0) shadow_count--;
   endtask

   task automatic shadow_touch(input int slot);
      int unsigned r;
      r = shadow_rank[slot];
      for (int i = 0; i < ENTRIES; i++)
         if (shadow_live[i] && shadow_rank[i] < r) shadow_rank[i]++;
      shadow_rank[slot] = 0;
   endtask

   function automatic int find_key(input logic [63:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (shadow_live[i] && shadow_key[i] == key) return i;
      return -1;
   endfunction

   // Work out the result of one request beat and advance the shadow cache.
   task automatic cache_apply(input logic [1:0] mode, input logic [63:0] key,
                              input logic [31:0] value, input logic [63:0] now,
                              output cache_result_type res);
      int slot;
      int unsigned cap;
      int lru;
      res = '{ST_MISS, 32'd0, 1'b0, 64'd0, 64'd0};
      case (mode)
         MODE_GET: begin
            slot = find_key(key);
            if (slot < 0) begin
               shadow_misses++;
            end else if (shadow_ttl != 0 && now - shadow_stamp[slot] > {32'd0, shadow_ttl}) begin
               shadow_drop(slot);
               shadow_misses++;
               res.status = ST_EXPIRED;
            end else begin
               shadow_touch(slot);
               res.value = shadow_value[slot];
               shadow_hits++;
               res.status = ST_HIT;
            end
         end
         MODE_PUT: begin
            slot = find_key(key);
            if (slot >= 0) begin
               shadow_value[slot] = value;
               shadow_stamp[slot] = now;
               shadow_touch(slot);
               res.status = ST_UPDATED;
            end else begin
               cap = shadow_capacity;
               if (cap == 0) cap = 1;
               if (cap > ENTRIES) cap = ENTRIES;
               while (shadow_count >= cap) begin
                  lru = -1;
                  for (int i = 0; i < ENTRIES; i++)
                     if (lru < 0 && shadow_live[i] && shadow_rank[i] + 1 == shadow_count) lru = i;
                  if (lru < 0) break;
                  shadow_drop(lru);
                  res.evicted = 1'b1;
               end
               slot = -1;
               for (int i = 0; i < ENTRIES; i++)
                  if (slot < 0 && !shadow_live[i]) slot = i;
               if (slot >= 0) begin
                  for (int i = 0; i < ENTRIES; i++)
                     if (shadow_live[i]) shadow_rank[i]++;
                  shadow_key[slot] = key;
                  shadow_value[slot] = value;
                  shadow_stamp[slot] = now;
                  shadow_rank[slot] = 0;
                  shadow_live[slot] = 1'b1;
                  shadow_count++;
               end
               res.status = ST_INSERTED;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) shadow_live[i] = 1'b0;
            shadow_count = 0;
            res.status = ST_CLEARED;
         end
         default: ;
      endcase
      res.hits = shadow_hits;
      res.misses = shadow_misses;
   endtask

   // Offer one request beat; hold it until accepted, then log the expectation.
   task automatic send_request(input logic [1:0] mode, input logic [63:0] key,
                               input logic [31:0] value, input logic [63:0] now,
                               input bit check_typed, input logic [2:0] want_status,
                               input logic [31:0] want_rd);
      cache_result_type res;
      while (!quiet_mode && $urandom_range(99) < 32) @(negedge clock);
      req_mode = mode;
      req_lookup_key = key;
      req_put_value = value;
      req_now_ms = now;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      cache_apply(mode, key, value, now, res);
      if (check_typed && (res.status != want_status || res.value != want_rd))
         report("typed row", 64'({res.status, res.value}), 64'({want_status, want_rd}));
      pending_results.push_back(res);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(input logic index, input logic [31:0] data);
      csr_index = index;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_CAPACITY) shadow_capacity = data[6:0];
      else shadow_ttl = data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Let every result drain, then let the clock run on before touching registers.
   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= quiet_mode || ($urandom_range(99) >= 32);
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      cache_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected beat", {61'd0, rsp_status}, 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report("status", {61'd0, rsp_status}, {61'd0, want.status});
            if (rsp_read_value !== want.value)
               report("read_value", {32'd0, rsp_read_value}, {32'd0, want.value});
            if (rsp_evicted !== want.evicted)
               report("evicted", {63'd0, rsp_evicted}, {63'd0, want.evicted});
            if (rsp_hits_total !== want.hits) report("hits_total", rsp_hits_total, want.hits);
            if (rsp_misses_total !== want.misses)
               report("misses_total", rsp_misses_total, want.misses);
         end
      end
   end

   // watchdog: count cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         timed_out = 1;
         $display("lru_cache_with_ttl_tb: errors");
         $finish;
      end
   end

   function automatic table_row_type row(input logic [1:0] m, input logic [63:0] k,
                                         input logic [31:0] v, input logic [63:0] t,
                                         input logic known = 0, input logic [2:0] st = ST_MISS,
                                         input logic [31:0] rd = 0);
      return '{m, k, v, t, known, st, rd};
   endfunction

   // one random request: mostly keys from a small pool so hits and updates happen
   task automatic random_request();
      logic [1:0]  mode;
      logic [63:0] key;
      logic [63:0] now;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 45) mode = MODE_GET;
      else if (pick < 93) mode = MODE_PUT;
      else if (pick < 97) mode = MODE_CLEAR;
      else mode = 2'd3;
      if ($urandom_range(9) < 7) key = key_pool[$urandom_range(7)] + 64'($urandom_range(5));
      else key = {$urandom, $urandom};
      clock_ms += 64'($urandom_range(40));
      now = clock_ms;
      if ($urandom_range(49) == 0) now = {$urandom, $urandom};   // clock jumps, maybe backwards
      send_request(mode, key, $urandom, now, 0, ST_MISS, 0);
   endtask

   initial begin
      table_row_type r;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_live[i] = 1'b0;
         shadow_rank[i] = 0;
      end
      shadow_count = 0;
      shadow_hits = '0;
      shadow_misses = '0;
      shadow_capacity = 7'd64;
      shadow_ttl = '0;
      for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};

      // directed rows; results typed in where they are obvious
      directed.push_back(row(MODE_GET,   64'd5, 0, 0, 1, ST_MISS, 0));
      directed.push_back(row(MODE_PUT,   64'd0, 32'h8000_0000, 0, 1, ST_INSERTED, 0));
      directed.push_back(row(MODE_PUT,   '1, 32'h7FFF_FFFF, '1, 1, ST_INSERTED, 0));
      directed.push_back(row(MODE_GET,   64'd0, 0, 10, 1, ST_HIT, 32'h8000_0000));
      directed.push_back(row(MODE_GET,   '1, 0, 10, 1, ST_HIT, 32'h7FFF_FFFF));
      directed.push_back(row(MODE_PUT,   64'd0, 32'hFFFF_FFFF, 20, 1, ST_UPDATED, 0));
      directed.push_back(row(MODE_GET,   64'd0, 0, 20, 1, ST_HIT, 32'hFFFF_FFFF));
      directed.push_back(row(2'd3,       64'd0, 0, 0, 1, ST_MISS, 0));
      directed.push_back(row(MODE_PUT,   64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA,
                             64'h5555_AAAA_5555_AAAA));
      directed.push_back(row(MODE_CLEAR, 64'd0, 0, 0, 1, ST_CLEARED, 0));
      directed.push_back(row(MODE_GET,   64'd0, 0, 0, 1, ST_MISS, 0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         r = directed[i];
         send_request(r.mode, r.key, r.value, r.now, r.known, r.status, r.rd);
      end
      wait_drained();

      // small capacity and a short ttl: eviction, expiry, clock going backwards
      write_reg(CSR_CAPACITY, 32'd2);
      write_reg(CSR_TTL, 32'd50);
      send_request(MODE_PUT, 64'd1, 32'd11, 64'd100, 0, ST_MISS, 0);
      send_request(MODE_PUT, 64'd2, 32'd22, 64'd100, 0, ST_MISS, 0);
      send_request(MODE_PUT, 64'd3, 32'd33, 64'd100, 0, ST_MISS, 0);   // evict
      send_request(MODE_GET, 64'd3, 0, 64'd150, 0, ST_MISS, 0);         // age equals ttl
      send_request(MODE_GET, 64'd2, 0, 64'd151, 0, ST_MISS, 0);         // expired
      send_request(MODE_PUT, 64'd3, 32'd44, 64'd999, 0, ST_MISS, 0);    // put on stale key
      send_request(MODE_GET, 64'd3, 0, 64'd5, 0, ST_MISS, 0);           // time went back
      wait_drained();
      // capacity zero acts as one, so the second put evicts the first
      write_reg(CSR_CAPACITY, 32'd0);
      write_reg(CSR_TTL, 32'hFFFF_FFFF);
      send_request(MODE_PUT, 64'd7, 32'd1, 64'd0, 0, ST_MISS, 0);
      send_request(MODE_PUT, 64'd8, 32'd2, 64'd0, 0, ST_MISS, 0);
      wait_drained();
      write_reg(CSR_CAPACITY, 32'd127);   // above the entry count
      write_reg(CSR_TTL, 32'd0);

      // random phases through several settings
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: write_reg(CSR_CAPACITY, 32'd127);
            1: write_reg(CSR_CAPACITY, 32'd1);
            2: write_reg(CSR_CAPACITY, 32'd4);
            3: write_reg(CSR_CAPACITY, 32'd64);
            4: write_reg(CSR_CAPACITY, 32'd3);
            default: write_reg(CSR_CAPACITY, 32'($urandom_range(1, 64)));
         endcase
         case (phase % 3)
            0: write_reg(CSR_TTL, 32'd0);
            1: write_reg(CSR_TTL, 32'($urandom_range(20, 200)));
            default: write_reg(CSR_TTL, $urandom);
         endcase
         quiet_mode = (phase == 3);
         for (int n = 0; n < 140; n++) begin
            if (phase == 2 && n == 20) begin
               // hold the receiver off while requests keep coming
               fork
                  begin
                     hold_off = 1;
                     repeat (600) @(negedge clock);
                     hold_off = 0;
                  end
               join_none
            end
            if (phase == 4 && n == 70) while (pending_results.size() != 0) @(negedge clock);
            random_request();
         end
      end
      quiet_mode = 0;

      while (pending_results.size() != 0) @(negedge clock);
      repeat (2 * ENTRIES + 20) @(negedge clock);
      if (error_count == 0)
         $display("lru_cache_with_ttl_tb: clean");
      else
         $display("lru_cache_with_ttl_tb: errors");
      $finish;
   end

endmodule
